[src/trf_pkg.sv]
// ----------------------------------------------------------------------------
// trf_pkg
// Shared types and constants of the TELNET receive filter.
// ----------------------------------------------------------------------------
package trf_pkg;

  localparam logic [7:0] BYTE_IAC  = 8'd255;
  localparam logic [7:0] BYTE_WONT = 8'd252;
  localparam logic [7:0] BYTE_WILL = 8'd251;
  localparam logic [7:0] BYTE_DO   = 8'd253;
  localparam logic [7:0] BYTE_CR   = 8'd13;
  localparam logic [7:0] BYTE_NUL  = 8'd0;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic REG_TELNET_ENABLE  = 1'b0;
  localparam logic REG_NO_CR_HANDLING = 1'b1;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_IAC  = 2'd1,
    ST_CMD  = 2'd2,
    ST_CR   = 2'd3
  } dec_state_t;

  typedef struct packed {
    logic telnet_enable;
    logic no_cr_handling;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       reply;
    logic [7:0] value;
  } push_t;

endpackage

[src/trf_in_if.sv]
// ----------------------------------------------------------------------------
// trf_in_if
// Input channel: one received network byte per item.
// ----------------------------------------------------------------------------
interface trf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[src/trf_out_if.sv]
// ----------------------------------------------------------------------------
// trf_out_if
// Result channel: data or reply byte with a last marker.
// ----------------------------------------------------------------------------
interface trf_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_last,
                  output ready);
endinterface

[src/trf_cfg.sv]
// ----------------------------------------------------------------------------
// trf_cfg
// APB-style register file holding the two mode bits.
// ----------------------------------------------------------------------------
module trf_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trf_pkg::CFG_AW-1:0]  paddr,
  input  logic [trf_pkg::CFG_DW-1:0]  pwdata,
  output logic [trf_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output trf_pkg::cfg_t               cfg
);

  trf_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.telnet_enable  <= 1'b1;
      cfg_r.no_cr_handling <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        trf_pkg::REG_TELNET_ENABLE:  cfg_r.telnet_enable  <= pwdata[0];
        trf_pkg::REG_NO_CR_HANDLING: cfg_r.no_cr_handling <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      trf_pkg::REG_TELNET_ENABLE:  prdata[0] = cfg_r.telnet_enable;
      trf_pkg::REG_NO_CR_HANDLING: prdata[0] = cfg_r.no_cr_handling;
      default: ;
    endcase
  end

endmodule

[src/trf_decode.sv]
// ----------------------------------------------------------------------------
// trf_decode
// TELNET framing decoder: state and held command, one byte per cycle while accept is high.
// ----------------------------------------------------------------------------
module trf_decode (
  input  logic           clk,
  input  logic           rst_n,
  input  trf_pkg::cfg_t  cfg,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  output trf_pkg::push_t push
);

  trf_pkg::dec_state_t state_r, state_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                emit;
  logic                reply;

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    reply     = 1'b0;
    if (!cfg.telnet_enable) begin
      emit = 1'b1;
    end else begin
      unique case (state_r)
        trf_pkg::ST_IAC: begin
          if (rx_byte == trf_pkg::BYTE_IAC) begin
            emit      = 1'b1;
            state_nxt = trf_pkg::ST_DATA;
          end else begin
            held_nxt  = rx_byte;
            state_nxt = trf_pkg::ST_CMD;
          end
        end
        trf_pkg::ST_CMD: begin
          state_nxt = trf_pkg::ST_DATA;
          if (held_r < trf_pkg::BYTE_WILL) begin
            emit = 1'b1;
          end else if (held_r == trf_pkg::BYTE_DO) begin
            emit  = 1'b1;
            reply = 1'b1;
          end
        end
        trf_pkg::ST_DATA, trf_pkg::ST_CR: begin
          priority if (state_r == trf_pkg::ST_CR && rx_byte == trf_pkg::BYTE_NUL) begin
            state_nxt = trf_pkg::ST_DATA;
          end else if (rx_byte == trf_pkg::BYTE_IAC) begin
            state_nxt = trf_pkg::ST_IAC;
          end else begin
            emit = 1'b1;
            if (rx_byte == trf_pkg::BYTE_CR && !cfg.no_cr_handling) begin
              state_nxt = trf_pkg::ST_CR;
            end else begin
              state_nxt = trf_pkg::ST_DATA;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign push.valid = accept && emit;
  assign push.reply = reply;
  assign push.value = rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trf_pkg::ST_DATA;
      held_r  <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

[src/trf_emit.sv]
// ----------------------------------------------------------------------------
// trf_emit
// Result register: holds one decoded item and plays out one or three results.
// ----------------------------------------------------------------------------
module trf_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  trf_pkg::push_t  push,
  output logic            space,
  trf_out_if.source       out_ch
);

  logic       valid_r;
  logic       reply_r;
  logic [7:0] byte_r;
  logic [1:0] idx_r;
  logic       last;
  logic       take;

  assign last  = !reply_r || (idx_r == 2'd2);
  assign take  = valid_r && out_ch.ready;
  assign space = !valid_r || (out_ch.ready && last);

  assign out_ch.valid    = valid_r;
  assign out_ch.out_kind = reply_r ? trf_pkg::KIND_REPLY : trf_pkg::KIND_DATA;
  assign out_ch.out_last = last;

  always_comb begin
    out_ch.out_byte = byte_r;
    if (reply_r) begin
      unique case (idx_r)
        2'd0:    out_ch.out_byte = trf_pkg::BYTE_IAC;
        2'd1:    out_ch.out_byte = trf_pkg::BYTE_WONT;
        default: out_ch.out_byte = byte_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (push.valid) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take) begin
      if (last) begin
        valid_r <= 1'b0;
        idx_r   <= '0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      reply_r <= push.reply;
      byte_r  <= push.value;
    end
  end

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |=> valid_r && idx_r == 2'd0)
    else $error("loaded item not presented");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    take && !last && !push.valid |=> valid_r && reply_r && idx_r == $past(idx_r) + 2'd1)
    else $error("reply sequence did not advance");

  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !reply_r |-> idx_r == 2'd0)
    else $error("data item with nonzero index");

  a_nolose: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> space)
    else $error("item loaded over a pending result");

endmodule

[src/telnet_receive_filter.sv]
// ----------------------------------------------------------------------------
// telnet_receive_filter
// Strips TELNET framing from a received byte stream and refuses DO requests.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      rx_byte[7:0]
//  out_ch   out  valid/ready      out_kind, out_byte[7:0], out_last
//  cfg_*    in   APB write/read   telnet_enable, no_cr_handling
//
//  One item per cycle unless held by a stall or a DO refusal; a result appears the cycle after its byte is taken.
//  A DO refusal occupies the result register for its three bytes, and in_ch
//  ready drops until its last byte is taken. Bytes that give no result
//  are taken without touching the result register.
//  Synchronous active-low reset: data state, held command 0, TELNET on.
//  A stall on out_ch holds the result and backs up into in_ch.
// ----------------------------------------------------------------------------
module telnet_receive_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  trf_in_if.sink                      in_ch,
  trf_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [trf_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [trf_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [trf_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  trf_pkg::cfg_t  cfg;
  trf_pkg::push_t push;
  logic           space;
  logic           accept;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  trf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  trf_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (accept),
    .rx_byte (in_ch.rx_byte),
    .push    (push)
  );

  trf_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

[sim/tb_telnet_receive_filter.sv]
// ----------------------------------------------------------------------------
// tb_telnet_receive_filter
// Self-checking bench for the TELNET receive filter. A queue-fed driver
// offers network bytes in random bursts while a built-in decoder predicts
// every data and refusal byte; a monitor checks each result in order.
// Register settings change only between drained phases, and the result side
// stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_telnet_receive_filter;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 80;
  localparam int PHASE_ITEMS    = 48;
  localparam int RANDOM_PHASES  = 6;
  localparam int CFG_AW         = trf_pkg::CFG_AW;
  localparam int CFG_DW         = trf_pkg::CFG_DW;

  localparam logic [CFG_AW-1:0] ADDR_TELNET_ENABLE  = {trf_pkg::REG_TELNET_ENABLE, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_NO_CR_HANDLING = {trf_pkg::REG_NO_CR_HANDLING, 2'b00};

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } rx_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  trf_in_if  rx_ch ();
  trf_out_if res_ch ();

  telnet_receive_filter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (rx_ch),
    .out_ch      (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  logic [7:0]  pending_rx[$];
  rx_result_t  decoded_q[$];
  int          bytes_queued = 0;
  int          bytes_taken  = 0;
  int          error_count  = 0;
  int          idle_cycles  = 0;
  bit          rx_fire      = 1'b0;
  bit          hold_armed   = 1'b0;

  // decoder copy: state, last command, register values
  trf_pkg::dec_state_t dec_state    = trf_pkg::ST_DATA;
  logic [7:0]          last_command = 8'd0;
  logic                telnet_on    = 1'b1;
  logic                cr_bypass    = 1'b0;

  task automatic emit(input logic kind, input logic [7:0] value, input logic last);
    decoded_q.push_back('{kind, value, last});
  endtask

  task automatic take_plain_byte(input logic [7:0] b);
    if (b == trf_pkg::BYTE_IAC) begin
      dec_state = trf_pkg::ST_IAC;
    end else begin
      emit(trf_pkg::KIND_DATA, b, 1'b1);
      dec_state = (b == trf_pkg::BYTE_CR && !cr_bypass) ? trf_pkg::ST_CR : trf_pkg::ST_DATA;
    end
  endtask

  task automatic decode_rx_byte(input logic [7:0] b);
    if (!telnet_on) begin
      emit(trf_pkg::KIND_DATA, b, 1'b1);
    end else begin
      case (dec_state)
        trf_pkg::ST_DATA: take_plain_byte(b);
        trf_pkg::ST_IAC: begin
          if (b == trf_pkg::BYTE_IAC) begin
            dec_state = trf_pkg::ST_DATA;
            emit(trf_pkg::KIND_DATA, trf_pkg::BYTE_IAC, 1'b1);
          end else begin
            last_command = b;
            dec_state = trf_pkg::ST_CMD;
          end
        end
        trf_pkg::ST_CMD: begin
          dec_state = trf_pkg::ST_DATA;
          if (last_command < trf_pkg::BYTE_WILL) begin
            emit(trf_pkg::KIND_DATA, b, 1'b1);
          end else if (last_command == trf_pkg::BYTE_DO) begin
            emit(trf_pkg::KIND_REPLY, trf_pkg::BYTE_IAC, 1'b0);
            emit(trf_pkg::KIND_REPLY, trf_pkg::BYTE_WONT, 1'b0);
            emit(trf_pkg::KIND_REPLY, b, 1'b1);
          end
        end
        default: begin
          if (b == trf_pkg::BYTE_NUL) dec_state = trf_pkg::ST_DATA;
          else take_plain_byte(b);
        end
      endcase
    end
  endtask

  task automatic send(input logic [7:0] b);
    pending_rx.push_back(b);
    bytes_queued++;
  endtask

  task automatic send_random_sequence();
    int n;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4: send(8'($urandom_range(0, 254)));
      5: begin
        send(trf_pkg::BYTE_CR);
        send($urandom_range(0, 1) ? trf_pkg::BYTE_NUL : 8'($urandom_range(0, 255)));
      end
      6: begin
        send(trf_pkg::BYTE_IAC);
        send(trf_pkg::BYTE_IAC);
      end
      7, 8: begin
        send(trf_pkg::BYTE_IAC);
        send(8'($urandom_range(0, 250)));
        send(8'($urandom_range(0, 255)));
      end
      9, 10: begin
        send(trf_pkg::BYTE_IAC);
        send(trf_pkg::BYTE_DO);
        send(8'($urandom_range(0, 255)));
      end
      11: begin
        send(trf_pkg::BYTE_IAC);
        send(8'($urandom_range(251, 254)));
        send(8'($urandom_range(0, 255)));
      end
      12: send(8'($urandom_range(0, 255)));
      13: send(trf_pkg::BYTE_IAC);
      14: send(trf_pkg::BYTE_NUL);
      default: begin
        n = $urandom_range(2, 6);
        repeat (n) send(8'($urandom_range(0, 254)));
      end
    endcase
  endtask

  task automatic apb_access(input logic is_write, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_register(input logic [CFG_AW-1:0] addr, input logic value);
    logic [CFG_DW-1:0] rdata;
    apb_access(1'b0, addr, '0, rdata);
    if (rdata !== CFG_DW'(value)) begin
      $error("cfg_prdata at 0x%0h: expected 0x%0h, got 0x%0h", addr, value, rdata);
      error_count++;
    end
  endtask

  task automatic write_register(input logic [CFG_AW-1:0] addr, input logic value);
    logic [CFG_DW-1:0] rdata;
    apb_access(1'b1, addr, CFG_DW'(value), rdata);
    if (addr == ADDR_TELNET_ENABLE) telnet_on = value;
    else cr_bypass = value;
    check_register(addr, value);
  endtask

  task automatic configure(input logic enable, input logic no_cr);
    write_register(ADDR_TELNET_ENABLE, enable);
    write_register(ADDR_NO_CR_HANDLING, no_cr);
  endtask

  task automatic drain();
    while (bytes_taken != bytes_queued || decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      rx_ch.valid <= 1'b0;
    end else if (rx_ch.valid && !rx_fire) begin
      // hold until taken
    end else if (gap_left > 0) begin
      gap_left--;
      rx_ch.valid <= 1'b0;
    end else if (pending_rx.size() == 0) begin
      rx_ch.valid <= 1'b0;
    end else begin
      rx_ch.valid   <= 1'b1;
      rx_ch.rx_byte <= pending_rx.pop_front();
      if (burst_left == 0)
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 12);
      burst_left--;
      if (burst_left == 0) begin
        case ($urandom_range(0, 7))
          0:       gap_left = $urandom_range(20, 40);
          1, 2, 3: gap_left = 0;
          default: gap_left = $urandom_range(1, 5);
        endcase
      end
    end
  end

  // receiver: stall pattern that cycles through four modes, plus one long hold
  int rcv_cycle = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    rcv_cycle++;
    if (hold_armed && rx_ch.valid) begin
      hold_left  = LONG_HOLD;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      case ((rcv_cycle / 40) % 4)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= 1'($urandom_range(0, 1));
        2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= (rcv_cycle % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    rx_result_t want;
    bit         progress;
    progress = 1'b0;
    rx_fire  = 1'b0;
    if (rst_n) begin
      if (rx_ch.valid && rx_ch.ready) begin
        decode_rx_byte(rx_ch.rx_byte);
        bytes_taken++;
        rx_fire  = 1'b1;
        progress = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        progress = 1'b1;
        if (decoded_q.size() == 0) begin
          $error("unexpected item: out_kind=%0d out_byte=%0d out_last=%0d",
                 res_ch.out_kind, res_ch.out_byte, res_ch.out_last);
          error_count++;
        end else begin
          want = decoded_q.pop_front();
          if (res_ch.out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, res_ch.out_kind);
            error_count++;
          end
          if (res_ch.out_byte !== want.value) begin
            $error("out_byte: expected %0d, got %0d", want.value, res_ch.out_byte);
            error_count++;
          end
          if (res_ch.out_last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, res_ch.out_last);
            error_count++;
          end
        end
      end
      if (cfg_psel && cfg_penable) progress = 1'b1;
    end
    idle_cycles = progress ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int phase_base;
    rst_n         = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'd0;
    res_ch.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_register(ADDR_TELNET_ENABLE, 1'b1);
    check_register(ADDR_NO_CR_HANDLING, 1'b0);

    // plain bytes, doubled IAC, commands below WILL, DO refusal, dropped options
    send(8'h00); send(8'hFE);
    send(trf_pkg::BYTE_IAC); send(trf_pkg::BYTE_IAC);
    send(trf_pkg::BYTE_IAC); send(8'd0);               send(8'hFF);
    send(trf_pkg::BYTE_IAC); send(8'd250);             send(8'h41);
    send(trf_pkg::BYTE_IAC); send(trf_pkg::BYTE_DO);   send(8'hFF);
    send(trf_pkg::BYTE_IAC); send(trf_pkg::BYTE_WILL); send(8'h01);
    send(trf_pkg::BYTE_IAC); send(trf_pkg::BYTE_WONT); send(8'h02);
    send(trf_pkg::BYTE_IAC); send(8'd254);             send(8'h03);
    // CR handling: strip, re-arm, IAC after CR; leave after-CR pending
    send(trf_pkg::BYTE_CR); send(trf_pkg::BYTE_CR); send(trf_pkg::BYTE_NUL);
    send(trf_pkg::BYTE_CR); send(trf_pkg::BYTE_IAC); send(trf_pkg::BYTE_IAC);
    send(trf_pkg::BYTE_CR);
    drain();

    // pending after-CR still strips one NUL once CR handling is off
    write_register(ADDR_NO_CR_HANDLING, 1'b1);
    send(trf_pkg::BYTE_NUL); send(trf_pkg::BYTE_CR);
    send(trf_pkg::BYTE_NUL); send(trf_pkg::BYTE_IAC);
    drain();

    // pass-through keeps the after-IAC state untouched
    write_register(ADDR_TELNET_ENABLE, 1'b0);
    send(trf_pkg::BYTE_IAC); send(trf_pkg::BYTE_NUL); send(trf_pkg::BYTE_CR); send(8'hFF);
    drain();

    configure(1'b1, 1'b0);
    send(trf_pkg::BYTE_IAC); send(trf_pkg::BYTE_IAC); send(trf_pkg::BYTE_DO);
    drain();
    write_register(ADDR_TELNET_ENABLE, 1'b0);
    send(8'h42);
    drain();
    write_register(ADDR_TELNET_ENABLE, 1'b1);
    send(8'h07);

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      drain();
      configure(k % 3 != 2, 1'(k % 2));
      if (k == 1) hold_armed = 1'b1;
      phase_base = bytes_queued;
      while (bytes_queued - phase_base < PHASE_ITEMS) send_random_sequence();
    end
    drain();
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
